/* design/set_assoc_cache_tag_fifo_defines.svh */
// assertion macros shared by the checker
`ifndef SET_ASSOC_CACHE_TAG_FIFO_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_FIFO_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SACTF_ASSERT_NOW(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
      else $error("sactf check failed");

// consequent must hold in the cycle after the antecedent
`define SACTF_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sactf check failed");

`endif

/* design/sactf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sactf_pkg;

   localparam int SETS       = 2048;
   localparam int WAYS       = 16;
   localparam int INDEX_BITS = 32;

   localparam int SET_BITS   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_BITS   = INDEX_BITS - SET_BITS;

   localparam int BASE_BITS     = 40;
   localparam int RSIZE_BITS    = 11;
   localparam int ADDR_BITS     = 48;
   localparam int CNT_BITS      = 32;
   localparam int SET_OUT_BITS  = 11;
   localparam int WAY_OUT_BITS  = 4;
   localparam int PROD_BITS     = INDEX_BITS + RSIZE_BITS;

   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = BASE_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BASE_OFFSET = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RECORD_SIZE = 2'd1;

   localparam logic [BASE_BITS-1:0]  BASE_RESET  = '0;
   localparam logic [RSIZE_BITS-1:0] RSIZE_RESET = 11'd16;

   localparam logic OP_LOOKUP     = 1'b0;
   localparam logic OP_INVALIDATE = 1'b1;

   // one memory row per set: tags, valid bits, replacement pointer
   localparam int TAGS_BITS = WAYS * TAG_BITS;
   localparam int VALID_LSB = TAGS_BITS;
   localparam int PTR_LSB   = TAGS_BITS + WAYS;
   localparam int ROW_BITS  = TAGS_BITS + WAYS + WAY_BITS;

   localparam int QDEPTH    = 4;
   localparam int QPTR_BITS = $clog2(QDEPTH);
   localparam int QCNT_BITS = $clog2(QDEPTH + 1);
   localparam int QSUM_BITS = QCNT_BITS + 1;

   typedef struct packed {
      logic                  opcode;
      logic [INDEX_BITS-1:0] idx;
      logic [PROD_BITS-1:0]  prod;
   } queue_item_type;

   typedef struct packed {
      logic                    hit;
      logic [SET_OUT_BITS-1:0] set_number;
      logic [WAY_OUT_BITS-1:0] way_number;
      logic                    fill_request;
      logic [ADDR_BITS-1:0]    fill_address;
      logic [CNT_BITS-1:0]     access_total;
      logic [CNT_BITS-1:0]     hit_total;
   } result_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

/* design/sactf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module sactf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/sactf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module sactf_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic                                 req_opcode,
   input  logic [sactf_pkg::INDEX_BITS-1:0]     req_lookup_index,
   input  logic [sactf_pkg::RSIZE_BITS-1:0]     record_size,
   output logic                                 front_valid,
   output sactf_pkg::queue_item_type            front_item
);

   import sactf_pkg::*;

   logic           valid_ff;
   queue_item_type item_ff;
   queue_item_type item_in;

   // fill offset is formed here so the back end only adds the base
   always_comb begin
      item_in.opcode = req_opcode;
      item_in.idx    = req_lookup_index;
      item_in.prod   = PROD_BITS'(req_lookup_index) * PROD_BITS'(record_size);
      if (req_opcode == OP_INVALIDATE) begin
         item_in.prod = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign front_valid = valid_ff;
   assign front_item  = item_ff;

endmodule

`default_nettype wire

/* design/sactf_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module sactf_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   input  sactf_pkg::queue_item_type         push_item,
   input  logic                              pop,
   output sactf_pkg::queue_item_type         pop_item,
   output logic                              empty,
   output logic [sactf_pkg::QCNT_BITS-1:0]   count
);

   import sactf_pkg::*;

   queue_item_type       entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign pop_item = entry_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

`default_nettype wire

/* design/sactf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module sactf_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   input  sactf_pkg::queue_item_type         q_item,
   output logic                              q_pop,
   input  logic [sactf_pkg::BASE_BITS-1:0]   base_offset,
   output logic                              rsp_valid,
   output sactf_pkg::result_type             rsp,
   output sactf_pkg::back_status_type        status
);

   import sactf_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_CMP   = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [SET_BITS-1:0] clr_addr_ff;
   logic [SET_BITS-1:0] clr_addr_in;
   logic                inv_ff;
   logic                inv_in;
   queue_item_type      cur_ff;
   queue_item_type      cur_in;
   logic [CNT_BITS-1:0] access_ff;
   logic [CNT_BITS-1:0] access_in;
   logic [CNT_BITS-1:0] hits_ff;
   logic [CNT_BITS-1:0] hits_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   result_type          rsp_ff;
   result_type          rsp_in;

   logic                ram_wr_en;
   logic [SET_BITS-1:0] ram_wr_addr;
   logic [ROW_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [SET_BITS-1:0] ram_rd_addr;
   logic [ROW_BITS-1:0] ram_rd_data;

   logic [TAGS_BITS-1:0] row_tags;
   logic [WAYS-1:0]      row_valid;
   logic [WAY_BITS-1:0]  row_ptr;
   logic [TAG_BITS-1:0]  cur_tag;
   logic [SET_BITS-1:0]  cur_set;
   logic [WAYS-1:0]      match;
   logic                 found;
   logic [WAY_BITS-1:0]  hit_way;
   logic [WAY_BITS-1:0]  next_ptr;
   logic [TAGS_BITS-1:0] new_tags;
   logic [WAYS-1:0]      new_valid;
   logic [ADDR_BITS-1:0] fill_addr;

   sactf_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (SETS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign row_tags  = ram_rd_data[TAGS_BITS-1:0];
   assign row_valid = ram_rd_data[VALID_LSB +: WAYS];
   assign row_ptr   = ram_rd_data[PTR_LSB +: WAY_BITS];
   assign cur_tag   = cur_ff.idx[INDEX_BITS-1:SET_BITS];
   assign cur_set   = cur_ff.idx[SET_BITS-1:0];

   // all ways compared at once, lowest matching way wins
   always_comb begin
      match   = '0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = row_valid[w] && (row_tags[w*TAG_BITS +: TAG_BITS] == cur_tag);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_BITS'(w);
         end
      end
      found = |match;
   end

   always_comb begin
      next_ptr  = (row_ptr == WAY_BITS'(WAYS - 1)) ? '0 : row_ptr + 1'b1;
      new_tags  = row_tags;
      new_valid = row_valid;
      new_tags[row_ptr*TAG_BITS +: TAG_BITS] = cur_tag;
      new_valid[row_ptr] = 1'b1;
      fill_addr = ADDR_BITS'(base_offset) + ADDR_BITS'(cur_ff.prod);
   end

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      inv_in       = inv_ff;
      cur_in       = cur_ff;
      access_in    = access_ff;
      hits_in      = hits_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cur_set;
      ram_wr_data  = {next_ptr, new_valid, new_tags};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = q_item.idx[SET_BITS-1:0];
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == SET_BITS'(SETS - 1)) begin
               clr_addr_in = '0;
               state_in    = ST_IDLE;
               inv_in      = 1'b0;
               // an invalidate answers once the sweep is done
               if (inv_ff) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.hit          = 1'b0;
                  rsp_in.set_number   = '0;
                  rsp_in.way_number   = '0;
                  rsp_in.fill_request = 1'b0;
                  rsp_in.fill_address = '0;
                  rsp_in.access_total = access_ff;
                  rsp_in.hit_total    = hits_ff;
               end
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_item.opcode == OP_INVALIDATE) begin
                  state_in    = ST_CLEAR;
                  inv_in      = 1'b1;
                  clr_addr_in = '0;
               end else begin
                  ram_rd_en = 1'b1;
                  cur_in    = q_item;
                  state_in  = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            access_in           = access_ff + 1'b1;
            rsp_valid_in        = 1'b1;
            rsp_in.set_number   = SET_OUT_BITS'(cur_set);
            rsp_in.access_total = access_ff + 1'b1;
            if (found) begin
               hits_in             = hits_ff + 1'b1;
               rsp_in.hit          = 1'b1;
               rsp_in.way_number   = WAY_OUT_BITS'(hit_way);
               rsp_in.fill_request = 1'b0;
               rsp_in.fill_address = '0;
               rsp_in.hit_total    = hits_ff + 1'b1;
            end else begin
               ram_wr_en           = 1'b1;
               rsp_in.hit          = 1'b0;
               rsp_in.way_number   = WAY_OUT_BITS'(row_ptr);
               rsp_in.fill_request = 1'b1;
               rsp_in.fill_address = fill_addr;
               rsp_in.hit_total    = hits_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         inv_ff       <= 1'b0;
         access_ff    <= '0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         inv_ff       <= inv_in;
         access_ff    <= access_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp             = rsp_ff;
   assign status.clearing = (state_ff == ST_CLEAR);

endmodule

`default_nettype wire

/* design/set_assoc_cache_tag_fifo.sv */
// Tag and control block of a 2048-set, 16-way record cache with round-robin
// replacement. After reset the block clears every row of its row memory with
// busy high. An item is taken when start is high and busy is low; a lookup then
// passes the front stage register and the queue; the back end reads the set's
// row, compares all ways, writes the updated row back on a miss and registers
// the result, and finishes one lookup before it takes the next. An invalidate
// sweeps every row again, with busy high, and answers when the sweep is done. A
// four-entry queue sits between intake and the back end, so busy also rises
// when it is nearly full. Each result is shown for exactly one cycle with
// rsp_strobe high and cannot be held off. The user must write registers through
// the csr_ port only while no item is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_tag_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [sactf_pkg::INDEX_BITS-1:0]    req_lookup_index,
   output logic                                rsp_strobe,
   output logic                                rsp_hit,
   output logic [sactf_pkg::SET_OUT_BITS-1:0]  rsp_set_number,
   output logic [sactf_pkg::WAY_OUT_BITS-1:0]  rsp_way_number,
   output logic                                rsp_fill_request,
   output logic [sactf_pkg::ADDR_BITS-1:0]     rsp_fill_address,
   output logic [sactf_pkg::CNT_BITS-1:0]      rsp_access_total,
   output logic [sactf_pkg::CNT_BITS-1:0]      rsp_hit_total,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sactf_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [sactf_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   import sactf_pkg::*;

   logic [BASE_BITS-1:0]  base_ff;
   logic [BASE_BITS-1:0]  base_in;
   logic [RSIZE_BITS-1:0] rsize_ff;
   logic [RSIZE_BITS-1:0] rsize_in;

   logic                  accept;
   logic                  front_valid;
   queue_item_type        front_item;
   logic                  q_pop;
   queue_item_type        q_item;
   logic                  q_empty;
   logic [QCNT_BITS-1:0]  q_count;
   logic                  rsp_valid;
   result_type            rsp;
   back_status_type       status;

   assign csr_ready = !reset;

   always_comb begin
      base_in  = base_ff;
      rsize_in = rsize_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_OFFSET: base_in  = csr_wdata[BASE_BITS-1:0];
            CSR_RECORD_SIZE: rsize_in = csr_wdata[RSIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         rsize_ff <= RSIZE_RESET;
      end else begin
         base_ff  <= base_in;
         rsize_ff <= rsize_in;
      end
   end

   // the front stage pushes without checking, so keep room for it
   assign busy = reset || status.clearing ||
                 ((QSUM_BITS'(q_count) + QSUM_BITS'(front_valid)) >= QSUM_BITS'(QDEPTH));
   assign accept = start && !busy;

   sactf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .req_opcode       (req_opcode),
      .req_lookup_index (req_lookup_index),
      .record_size      (rsize_ff),
      .front_valid      (front_valid),
      .front_item       (front_item)
   );

   sactf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty),
      .count     (q_count)
   );

   sactf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .base_offset (base_ff),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp),
      .status      (status)
   );

   assign rsp_strobe       = rsp_valid;
   assign rsp_hit          = rsp.hit;
   assign rsp_set_number   = rsp.set_number;
   assign rsp_way_number   = rsp.way_number;
   assign rsp_fill_request = rsp.fill_request;
   assign rsp_fill_address = rsp.fill_address;
   assign rsp_access_total = rsp.access_total;
   assign rsp_hit_total    = rsp.hit_total;

endmodule

`default_nettype wire

/* design/sactf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "set_assoc_cache_tag_fifo_defines.svh"

module sactf_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_strobe
);

   // reset holds off intake
   `SACTF_ASSERT_NOW(a_busy_in_reset, clock, reset, busy)
   // the row sweep after reset keeps intake closed
   `SACTF_ASSERT_NEXT(a_busy_after_reset, clock, reset, busy)
   // no result right after reset
   `SACTF_ASSERT_NEXT(a_quiet_after_reset, clock, reset, !rsp_strobe)
   // read then compare means results never come in adjacent cycles
   `SACTF_ASSERT_NEXT(a_strobe_spacing, clock, rsp_strobe, !rsp_strobe)

endmodule

bind set_assoc_cache_tag_fifo sactf_checker u_checker (.*);

`default_nettype wire
